### design/assert_macros.svh
// Assertion macros shared by the cache tag directory RTL.
// Assertions are compiled only when SYNTHESIS is not defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Concurrent implication or plain property checked on every rising edge.
`define SACTL_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sactl assertion failed");
// Condition that must never be seen on a rising edge.
`define SACTL_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sactl forbidden condition seen");
`else
`define SACTL_ASSERT(name, clk, rst_n, prop)
`define SACTL_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

### design/sactl_pkg.sv
// Types and constants of the set-associative cache tag directory.
// No dependencies; used by every module of the block but sactl_row_ram.
package sactl_pkg;

  localparam int unsigned SETS        = 64;
  localparam int unsigned WAYS        = 4;
  localparam int unsigned BLOCK_BYTES = 32;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned STAMP_W = 31;
  localparam int unsigned OFS_W   = $clog2(BLOCK_BYTES / 2);
  localparam int unsigned SET_W   = $clog2(SETS);
  localparam int unsigned TAG_W   = ADDR_W - OFS_W - SET_W;
  localparam int unsigned WAY_W   = $clog2(WAYS);

  // Operation codes; any other code behaves as a probe.
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_PROBE = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [ADDR_W-1:0]  address;
    logic [STAMP_W-1:0] time_stamp;
  } in_word_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
  } out_word_t;

  // One way of a set as kept in the row memory.
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
    logic               modified;
  } way_entry_t;

  typedef way_entry_t [WAYS-1:0] row_t;

  // Lookup verdict handed from the way selector to the control.
  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] victim;
  } sel_t;

endpackage

### design/sactl_row_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sactl_row_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/sactl_way_select.sv
// Tag compare and LRU victim choice over all ways of one set.
// Depends on sactl_pkg.
module sactl_way_select (
  input  sactl_pkg::row_t                   row_i,
  input  logic [sactl_pkg::WAYS-1:0]        valid_i,
  input  logic [sactl_pkg::TAG_W-1:0]       tag_i,
  output sactl_pkg::sel_t                   sel_o
);
  import sactl_pkg::*;

  logic               hit;
  logic [WAY_W-1:0]   hit_way;
  logic               found_free;
  logic [WAY_W-1:0]   free_way;
  logic [STAMP_W-1:0] best_stamp;
  logic [WAY_W-1:0]   best_way;

  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    found_free = 1'b0;
    free_way   = '0;
    best_stamp = row_i[0].stamp;
    best_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && valid_i[w] && (row_i[w].tag == tag_i)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!found_free && !valid_i[w]) begin
        found_free = 1'b1;
        free_way   = WAY_W'(w);
      end
    end
    // Strict compare keeps the lowest way when stamps tie.
    for (int w = 1; w < WAYS; w++) begin
      if (row_i[w].stamp < best_stamp) begin
        best_stamp = row_i[w].stamp;
        best_way   = WAY_W'(w);
      end
    end
  end

  assign sel_o.hit     = hit;
  assign sel_o.hit_way = hit_way;
  assign sel_o.victim  = found_free ? free_way : best_way;

endmodule

### design/set_assoc_cache_tag_lru_core.sv
// Top level of the set-associative cache tag directory with timestamp LRU.
// Depends on sactl_pkg, sactl_row_ram, sactl_way_select and assert_macros.svh.
//
//  port group    direction  payload        handshake
//  in_word_i     in         sactl in word  in_valid_i / in_stall_o
//  out_word_o    out        sactl out word out_valid_o / out_stall_i
//
// Each word is handled in two steps: the set's row is read from the row memory,
// then the tags are compared, the victim is picked and, for reads and writes,
// the row is written back. Because of the row memory's single read port, the
// next word is taken only once the lookup step has finished.
// Reset clears all line valid bits at once in flip-flops; no clearing pass.
// A stalled output holds the lookup stage until the output register frees up.
module set_assoc_cache_tag_lru_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sactl_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sactl_pkg::out_word_t out_word_o
);
  import sactl_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } state_e;

  state_e    st_q;
  in_word_t  req_q;
  logic      out_valid_q;
  out_word_t out_word_q;
  out_word_t result_d;

  logic [SETS-1:0][WAYS-1:0] valid_q;

  logic               in_accept;
  logic               out_free;
  logic               lookup_done;
  logic               update;
  logic [SET_W-1:0]   in_set;
  logic [SET_W-1:0]   req_set;
  logic [TAG_W-1:0]   req_tag;
  logic [$bits(row_t)-1:0] ram_rdata;
  row_t               rd_row;
  row_t               new_row;
  logic               ram_we;
  sel_t               sel;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (st_q != S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign lookup_done = (st_q == S_LOOKUP) && out_free;

  assign in_set  = in_word_i.address[OFS_W +: SET_W];
  assign req_set = req_q.address[OFS_W +: SET_W];
  assign req_tag = req_q.address[ADDR_W-1 -: TAG_W];
  assign update  = (req_q.operation == OP_READ) || (req_q.operation == OP_WRITE);
  assign ram_we  = lookup_done && update;
  assign rd_row  = row_t'(ram_rdata);

  sactl_row_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (req_set),
    .wdata_i (new_row),
    .re_i    (in_accept),
    .raddr_i (in_set),
    .rdata_o (ram_rdata)
  );

  sactl_way_select u_way_select (
    .row_i   (rd_row),
    .valid_i (valid_q[req_set]),
    .tag_i   (req_tag),
    .sel_o   (sel)
  );

  // Read-modify-write of the whole set row.
  always_comb begin
    new_row = rd_row;
    if (sel.hit) begin
      new_row[sel.hit_way].stamp = req_q.time_stamp;
      if (req_q.operation == OP_WRITE) begin
        new_row[sel.hit_way].modified = 1'b1;
      end
    end else begin
      new_row[sel.victim].tag      = req_tag;
      new_row[sel.victim].stamp    = req_q.time_stamp;
      new_row[sel.victim].modified = 1'b0;
    end
  end

  always_comb begin
    result_d.hit = sel.hit;
    if (sel.hit) begin
      result_d.way = sel.hit_way;
    end else if (update) begin
      result_d.way = sel.victim;
    end else begin
      result_d.way = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      req_q       <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (in_accept) begin
            req_q <= in_word_i;
            st_q  <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (out_free) begin
            st_q <= S_IDLE;
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
      if (lookup_done) begin
        out_valid_q <= 1'b1;
        out_word_q  <= result_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // A miss that fills a line makes it valid; nothing ever invalidates a line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we && !sel.hit) begin
      valid_q[req_set][sel.victim] <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `SACTL_ASSERT_NEVER(a_we_only_in_lookup, clk_i, rst_ni, ram_we && (st_q != S_LOOKUP))
  `SACTL_ASSERT_NEVER(a_no_read_during_write, clk_i, rst_ni, in_accept && ram_we)
  `SACTL_ASSERT(a_out_from_lookup, clk_i, rst_ni, out_valid_q && !$past(out_valid_q) |-> $past(st_q == S_LOOKUP))
  `SACTL_ASSERT_NEVER(a_hit_on_valid_way, clk_i, rst_ni, (st_q == S_LOOKUP) && sel.hit && !valid_q[req_set][sel.hit_way])
  `SACTL_ASSERT(a_fill_sets_valid, clk_i, rst_ni, ram_we && !sel.hit |=> valid_q[$past(req_set)][$past(sel.victim)])

endmodule

### test/set_assoc_cache_tag_lru_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the set-associative cache tag directory with timestamp LRU.
// Depends on sactl_pkg and set_assoc_cache_tag_lru_core; predicts untyped words in place.
module set_assoc_cache_tag_lru_core_test;
  import sactl_pkg::*;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int unsigned HALF_BLOCK = BLOCK_BYTES / 2;
  localparam int unsigned LINES = SETS * WAYS;
  localparam int unsigned TAG_POOL = 8;
  localparam int unsigned PHASE_WORDS = 200;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned STUCK_LIMIT = 4000;

  typedef enum logic [1:0] {
    LINE_INVALID   = 2'd0,
    LINE_EXCLUSIVE = 2'd1,
    LINE_MODIFIED  = 2'd2
  } line_state_e;

  typedef struct {
    logic [1:0]         operation;
    logic [ADDR_W-1:0]  address;
    logic [STAMP_W-1:0] time_stamp;
    bit                 typed;
    logic               hit;
    logic [WAY_W-1:0]   way;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  // Shadow copy of the tag directory.
  logic [TAG_W-1:0]   dir_tag   [LINES];
  line_state_e        dir_state [LINES];
  logic [STAMP_W-1:0] dir_stamp [LINES];

  out_word_t          pending_results [$];
  stim_row_t          stim_rows [$];
  logic [TAG_W-1:0]   tag_pool [TAG_POOL];
  logic [SET_W-1:0]   hot_sets [4];
  logic [STAMP_W-1:0] clock_now;
  int unsigned        fail_count;
  int unsigned        stuck_cycles;
  int unsigned        hold_requests;
  bit                 tx_steady;
  bit                 rx_steady;

  set_assoc_cache_tag_lru_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Looks up one access in the shadow directory and applies its update.
  function automatic out_word_t access_directory(in_word_t w);
    int unsigned      blk;
    int unsigned      base;
    int unsigned      victim;
    logic [TAG_W-1:0] tag;
    bit               updates;
    bit               found_free;
    out_word_t        r;
    blk = w.address / HALF_BLOCK;
    base = (blk % SETS) * WAYS;
    tag = TAG_W'(blk / SETS);
    updates = (w.operation == OP_READ) || (w.operation == OP_WRITE);
    for (int unsigned k = 0; k < WAYS; k++) begin
      if (dir_state[base + k] != LINE_INVALID && dir_tag[base + k] == tag) begin
        if (updates) begin
          dir_stamp[base + k] = w.time_stamp;
          if (w.operation == OP_WRITE) dir_state[base + k] = LINE_MODIFIED;
        end
        r.hit = 1'b1;
        r.way = WAY_W'(k);
        return r;
      end
    end
    r = '0;
    if (!updates) return r;
    victim = 0;
    found_free = 1'b0;
    for (int unsigned k = 0; k < WAYS; k++) begin
      if (!found_free && dir_state[base + k] == LINE_INVALID) begin
        victim = k;
        found_free = 1'b1;
      end
    end
    // With a full set the oldest stamp goes; strict compare keeps the lowest way on ties.
    if (!found_free) begin
      for (int unsigned k = 1; k < WAYS; k++) begin
        if (dir_stamp[base + k] < dir_stamp[base + victim]) victim = k;
      end
    end
    dir_tag[base + victim] = tag;
    dir_stamp[base + victim] = w.time_stamp;
    dir_state[base + victim] = LINE_EXCLUSIVE;
    r.way = WAY_W'(victim);
    return r;
  endfunction

  function automatic in_word_t random_access();
    in_word_t         w;
    int unsigned      pick;
    logic [OFS_W-1:0] ofs;
    pick = $urandom_range(0, 99);
    if (pick < 38) w.operation = OP_READ;
    else if (pick < 70) w.operation = OP_WRITE;
    else if (pick < 90) w.operation = OP_PROBE;
    else w.operation = OP_RESERVED;
    ofs = OFS_W'($urandom);
    // Mostly a few hot sets and a small tag pool, so that sets fill up and evict.
    if ($urandom_range(0, 99) < 88) begin
      w.address = {tag_pool[$urandom_range(0, TAG_POOL - 1)], hot_sets[$urandom_range(0, 3)],
                   ofs};
    end else begin
      w.address = $urandom;
    end
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      clock_now = clock_now + STAMP_W'($urandom_range(0, 3));
      w.time_stamp = clock_now;
    end else if (pick < 90) begin
      w.time_stamp = STAMP_W'($urandom);
    end else if (pick < 95) begin
      w.time_stamp = clock_now - STAMP_W'($urandom_range(0, 50));
    end else begin
      w.time_stamp = pick[0] ? '1 : '0;
    end
    return w;
  endfunction

  task automatic add_row(logic [1:0] op, logic [ADDR_W-1:0] addr, logic [STAMP_W-1:0] stamp,
                         bit typed, logic hit, logic [WAY_W-1:0] way);
    stim_row_t row;
    row.operation = op;
    row.address = addr;
    row.time_stamp = stamp;
    row.typed = typed;
    row.hit = hit;
    row.way = way;
    stim_rows = {stim_rows, row};
  endtask

  // Entered and left at a falling edge; valid stays high on return.
  task automatic send_word(in_word_t w, bit typed, out_word_t typed_result);
    out_word_t predicted;
    while (!tx_steady && $urandom_range(0, 99) < 24) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    predicted = access_directory(w);
    if (typed) predicted = typed_result;
    pending_results = {pending_results, predicted};
    @(negedge clk_i);
  endtask

  task automatic new_working_set(bit edge_sets);
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int k = 2; k < TAG_POOL; k++) tag_pool[k] = TAG_W'($urandom);
    for (int k = 0; k < 4; k++) hot_sets[k] = SET_W'($urandom);
    if (edge_sets) begin
      hot_sets[0] = '0;
      hot_sets[1] = '1;
    end
  endtask

  task automatic check_result(out_word_t got);
    out_word_t want;
    if (pending_results.size() == 0) begin
      $error("result word with nothing expected: hit=%0d way=%0d", got.hit, got.way);
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit mismatch: expected %0d, actual %0d", want.hit, got.hit);
        fail_count++;
      end
      if (got.way !== want.way) begin
        $error("way mismatch: expected %0d, actual %0d", want.way, got.way);
        fail_count++;
      end
    end
  endtask

  // Receiver: random stalls, a quiet stretch, and one long hold-off on request.
  initial begin
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left = 0;
    holds_served = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_result(out_word_o);
      @(negedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !rx_steady && ($urandom_range(0, 99) < 24);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    out_word_t typed_result;
    in_word_t  w;
    stim_row_t row;
    for (int k = 0; k < LINES; k++) begin
      dir_tag[k] = '0;
      dir_state[k] = LINE_INVALID;
      dir_stamp[k] = '0;
    end
    fail_count = 0;
    stuck_cycles = 0;
    hold_requests = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    clock_now = STAMP_W'(1000);
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;

    // Empty directory, both ends of the address and stamp ranges, the unused opcode.
    add_row(OP_PROBE,    32'h0000_0000, 31'd0,          1, 1'b0, 2'd0);
    add_row(OP_READ,     32'h0000_0000, 31'd0,          1, 1'b0, 2'd0);
    add_row(OP_PROBE,    32'h0000_000F, 31'd0,          1, 1'b1, 2'd0);
    add_row(OP_READ,     32'hFFFF_FFFF, 31'h7FFF_FFFF,  1, 1'b0, 2'd0);
    add_row(OP_WRITE,    32'hFFFF_FFF0, 31'h7FFF_FFFF,  1, 1'b1, 2'd0);
    add_row(OP_RESERVED, 32'h0000_0010, 31'd5,          1, 1'b0, 2'd0);
    add_row(OP_PROBE,    32'h0000_0010, 31'd5,          1, 1'b0, 2'd0);
    // A write miss fills like a read miss; the next write hits.
    add_row(OP_WRITE,    32'h0000_0020, 31'd1,          1, 1'b0, 2'd0);
    add_row(OP_WRITE,    32'h0000_0020, 31'd2,          1, 1'b1, 2'd0);
    // Set 3: fill all ways with equal stamps, then evict on a tie.
    add_row(OP_READ,     32'h0000_0430, 31'd7,          1, 1'b0, 2'd0);
    add_row(OP_READ,     32'h0000_0830, 31'd7,          1, 1'b0, 2'd1);
    add_row(OP_WRITE,    32'h0000_0C30, 31'd7,          1, 1'b0, 2'd2);
    add_row(OP_READ,     32'h0000_1030, 31'd7,          1, 1'b0, 2'd3);
    add_row(OP_READ,     32'h0000_1430, 31'd7,          1, 1'b0, 2'd0);
    add_row(OP_PROBE,    32'h0000_0430, 31'd7,          1, 1'b0, 2'd0);
    // Stamps older than those already stored, a hit that moves a stamp back.
    add_row(OP_READ,     32'h0000_1830, 31'd0,          0, 1'b0, 2'd0);
    add_row(OP_WRITE,    32'h0000_0C30, 31'd2,          0, 1'b0, 2'd0);
    add_row(OP_READ,     32'h0000_1C30, 31'd100,        0, 1'b0, 2'd0);
    add_row(OP_READ,     32'h0000_2030, 31'd100,        0, 1'b0, 2'd0);
    add_row(OP_PROBE,    32'h0000_0C30, 31'd100,        0, 1'b0, 2'd0);
    add_row(OP_READ,     32'hFFFF_FC30, 31'h7FFF_FFFF,  0, 1'b0, 2'd0);
    add_row(OP_PROBE,    32'hFFFF_FC3F, 31'd0,          0, 1'b0, 2'd0);
    add_row(OP_READ,     32'hA5A5_5A5A, 31'h2AAA_AAAA,  0, 1'b0, 2'd0);
    add_row(OP_RESERVED, 32'hFFFF_FFFF, 31'd0,          1, 1'b1, 2'd0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (stim_rows[k]) begin
      row = stim_rows[k];
      w.operation = row.operation;
      w.address = row.address;
      w.time_stamp = row.time_stamp;
      typed_result.hit = row.hit;
      typed_result.way = row.way;
      send_word(w, row.typed, typed_result);
    end
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk_i);

    for (int phase = 0; phase < 4; phase++) begin
      new_working_set(phase == 3);
      tx_steady = (phase == 1);
      rx_steady = (phase == 1);
      // The output stays blocked while words keep coming, so the input must stall.
      if (phase == 2) hold_requests++;
      for (int n = 0; n < PHASE_WORDS; n++) send_word(random_access(), 1'b0, '0);
      in_valid_i <= 1'b0;
      wait (pending_results.size() == 0);
      @(negedge clk_i);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/sactl_pkg.sv
design/sactl_row_ram.sv
design/sactl_way_select.sv
design/set_assoc_cache_tag_lru_core.sv
test/set_assoc_cache_tag_lru_core_test.sv
